FILE: hw/rtl/bls_pkg.sv
package bls_pkg;

  localparam int unsigned COORD_BITS  = 6;
  localparam int unsigned ERR_BITS    = COORD_BITS + 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] count_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic signed [1:0]            dir_t;

  localparam dir_t DIR_POS  = 2'sb01;
  localparam dir_t DIR_NEG  = 2'sb11;
  localparam dir_t DIR_NONE = 2'sb00;

  // Segment set up for stepping: start point, directions, deltas, initial error
  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    dir_t   dir_x;
    dir_t   dir_y;
    logic   axes_swapped;
    count_t major_delta;
    count_t minor_delta;
    err_t   err_init;
  } seg_desc_t;

endpackage

FILE: hw/rtl/bls_seg_if.sv
interface bls_seg_if
  import bls_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t end_x;
  coord_t end_y;

  modport source (output valid, output start_x, output start_y, output end_x,
                  output end_y, input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

FILE: hw/rtl/bls_pix_if.sv
interface bls_pix_if
  import bls_pkg::*;
();
  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   is_last;

  modport source (output valid, output pixel_x, output pixel_y, output is_last,
                  input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input is_last,
                  output ready);
endinterface

FILE: hw/rtl/bls_front.sv
module bls_front
  import bls_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  bls_seg_if.sink    seg_i,
  output logic       desc_valid_o,
  input  logic       desc_ready_i,
  output seg_desc_t  desc_o
);

  logic              valid_q, valid_d;
  seg_desc_t         desc_q, desc_d;
  logic signed [COORD_BITS:0] dx, dy, ndx, ndy;
  count_t            adx, ady, maj, mnr;
  logic              swap, accept;

  assign seg_i.ready  = !valid_q || desc_ready_i;
  assign accept       = seg_i.valid && seg_i.ready;
  assign desc_valid_o = valid_q;
  assign desc_o       = desc_q;

  always_comb begin
    dx   = {seg_i.end_x[COORD_BITS-1], seg_i.end_x}
         - {seg_i.start_x[COORD_BITS-1], seg_i.start_x};
    dy   = {seg_i.end_y[COORD_BITS-1], seg_i.end_y}
         - {seg_i.start_y[COORD_BITS-1], seg_i.start_y};
    ndx  = -dx;
    ndy  = -dy;
    adx  = dx[COORD_BITS] ? ndx[COORD_BITS-1:0] : dx[COORD_BITS-1:0];
    ady  = dy[COORD_BITS] ? ndy[COORD_BITS-1:0] : dy[COORD_BITS-1:0];
    swap = ady > adx;
    maj  = swap ? ady : adx;
    mnr  = swap ? adx : ady;

    desc_d.start_x      = seg_i.start_x;
    desc_d.start_y      = seg_i.start_y;
    desc_d.dir_x        = dx[COORD_BITS] ? DIR_NEG : ((adx != '0) ? DIR_POS : DIR_NONE);
    desc_d.dir_y        = dy[COORD_BITS] ? DIR_NEG : ((ady != '0) ? DIR_POS : DIR_NONE);
    desc_d.axes_swapped = swap;
    desc_d.major_delta  = maj;
    desc_d.minor_delta  = mnr;
    desc_d.err_init     = $signed({1'b0, mnr, 1'b0}) - $signed({2'b00, maj});
  end

  always_comb begin
    valid_d = valid_q;
    if (desc_ready_i) begin
      valid_d = 1'b0;
    end
    // drop zero-length segments here
    if (accept && (maj != '0)) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_d;
    end
  end

endmodule

FILE: hw/rtl/bls_queue.sv
module bls_queue
  import bls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  input  seg_desc_t push_data_i,
  output logic      pop_valid_o,
  input  logic      pop_ready_i,
  output seg_desc_t pop_data_o
);

  seg_desc_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0]   cnt_q, cnt_d;
  logic                   push, pop;

  assign push_ready_o = cnt_q != QCNT_BITS'(QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/bls_back.sv
module bls_back
  import bls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      desc_valid_i,
  output logic      desc_ready_o,
  input  seg_desc_t desc_i,
  bls_pix_if.source pix_o
);

  logic      busy_q, busy_d;
  logic      out_valid_q, out_valid_d;
  coord_t    cur_x_q, cur_y_q, pixel_x_q, pixel_y_q;
  logic      is_last_q;
  err_t      err_q;
  count_t    steps_q;
  seg_desc_t seg_q;
  logic      load, advance, minor_step;
  logic signed [ERR_BITS:0] err_a, err_b;
  coord_t    step_x, step_y;

  assign desc_ready_o = !busy_q;
  assign load         = desc_valid_i && !busy_q;
  assign advance      = busy_q && (!out_valid_q || pix_o.ready);

  assign pix_o.valid   = out_valid_q;
  assign pix_o.pixel_x = pixel_x_q;
  assign pix_o.pixel_y = pixel_y_q;
  assign pix_o.is_last = is_last_q;

  always_comb begin
    minor_step = err_q > 0;
    // take the minor step first (error drops by 2*major), then the major step
    err_a = minor_step
          ? ({err_q[ERR_BITS-1], err_q} - $signed({1'b0, seg_q.major_delta, 1'b0}))
          : {err_q[ERR_BITS-1], err_q};
    err_b = err_a + $signed({2'b00, seg_q.minor_delta, 1'b0});
    step_x = coord_t'({{(COORD_BITS-2){seg_q.dir_x[1]}}, seg_q.dir_x});
    step_y = coord_t'({{(COORD_BITS-2){seg_q.dir_y[1]}}, seg_q.dir_y});
  end

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      if (steps_q == count_t'(1)) begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      seg_q   <= desc_i;
      cur_x_q <= desc_i.start_x;
      cur_y_q <= desc_i.start_y;
      err_q   <= desc_i.err_init;
      steps_q <= desc_i.major_delta;
    end else if (advance) begin
      pixel_x_q <= cur_x_q;
      pixel_y_q <= cur_y_q;
      is_last_q <= steps_q == count_t'(1);
      steps_q   <= steps_q - 1'b1;
      err_q     <= err_b[ERR_BITS-1:0];
      if (seg_q.axes_swapped) begin
        cur_y_q <= cur_y_q + step_y;
        if (minor_step) begin
          cur_x_q <= cur_x_q + step_x;
        end
      end else begin
        cur_x_q <= cur_x_q + step_x;
        if (minor_step) begin
          cur_y_q <= cur_y_q + step_y;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/bresenham_line_stepper.sv
// Line segment stepper: each request on seg_i carries two signed endpoints, and
// pix_o returns the segment's pixels from the start point up to one step short of
// the end point, max(|dx|,|dy|) of them, with is_last on the final one; a
// zero-length segment returns nothing. The back-end stepper emits one pixel per
// cycle while the receiver is ready, and loads the next segment only after it has
// emitted the last pixel of the current one. The front end sets up each segment
// combinationally into a register and holds up to two prepared segments in a
// queue, so new requests are taken while a line is still stepping.
module bresenham_line_stepper
  import bls_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  bls_seg_if.sink   seg_i,
  bls_pix_if.source pix_o
);

  logic      f_valid, f_ready, b_valid, b_ready;
  seg_desc_t f_desc, b_desc;

  bls_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seg_i        (seg_i),
    .desc_valid_o (f_valid),
    .desc_ready_i (f_ready),
    .desc_o       (f_desc)
  );

  bls_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_desc),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_desc)
  );

  bls_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (b_valid),
    .desc_ready_o (b_ready),
    .desc_i       (b_desc),
    .pix_o        (pix_o)
  );

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  import bls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned N_DIRECTED   = 22;
  localparam int unsigned N_RANDOM     = 200;
  localparam int unsigned CALM_ITEMS   = 60;
  localparam int unsigned IDLE_PERCENT = 36;
  localparam int unsigned TAIL_CYCLES  = 150;

  typedef enum logic [1:0] {
    LINE_IDLE,
    LINE_AXIS,
    LINE_DIAG,
    LINE_GENERAL
  } line_mode_e;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  // One segment request; golden rows carry their result directly: either
  // nothing, or a single pixel at (gx, gy) flagged as last.
  typedef struct {
    int sx;
    int sy;
    int ex;
    int ey;
    bit golden;
    bit g_pix;
    int gx;
    int gy;
  } seg_row_t;

  logic clk_i;
  logic rst_ni;

  bls_seg_if seg_if ();
  bls_pix_if pix_if ();

  bresenham_line_stepper dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .seg_i  (seg_if.sink),
    .pix_o  (pix_if.source)
  );

  pixel_t      pending_pixels[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          gaps_on;
  bit          stall_on;

  seg_row_t directed_rows[N_DIRECTED] = '{
    '{  0,   0,   0,   0, 1, 0,   0,   0},  // zero length at origin
    '{-32, -32, -32, -32, 1, 0,   0,   0},  // zero length at lower corner
    '{ 31,  31,  31,  31, 1, 0,   0,   0},  // zero length at upper corner
    '{  0,   0,   1,   0, 1, 1,   0,   0},  // single horizontal step
    '{ 31,  31,  30,  30, 1, 1,  31,  31},  // single diagonal step
    '{-32, -32, -32, -31, 1, 1, -32, -32},  // single vertical step
    '{-32,   5,  31,   5, 0, 0,   0,   0},  // full-width horizontal
    '{ 31,  -7, -32,  -7, 0, 0,   0,   0},
    '{  3, -32,   3,  31, 0, 0,   0,   0},  // full-height vertical
    '{ -9,  31,  -9, -32, 0, 0,   0,   0},
    '{-32, -32,  31,  31, 0, 0,   0,   0},  // full diagonals
    '{ 31, -32, -32,  31, 0, 0,   0,   0},
    '{  0,   0,  31,   5, 0, 0,   0,   0},  // shallow
    '{  0,   0,   3, -20, 0, 0,   0,   0},  // steep
    '{ 10,  10, -20,   2, 0, 0,   0,   0},
    '{ -5,  20, -12, -30, 0, 0,   0,   0},
    '{-32, -32,  31,  30, 0, 0,   0,   0},  // minor one short of major
    '{ 31,  31, -32,  30, 0, 0,   0,   0},  // minor of one, longest major
    '{-32,  31, -31, -32, 0, 0,   0,   0},
    '{ -1,  -1,  -2,  -3, 0, 0,   0,   0},
    '{ 21, -10, -21,  10, 0, 0,   0,   0},
    '{ 21, -22, -22,  21, 0, 0,   0,   0}   // alternating bit patterns
  };

  function automatic void predict_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey);
    int         x;
    int         y;
    int         ddx;
    int         ddy;
    int         adx;
    int         ady;
    int         step_x;
    int         step_y;
    int         major;
    int         minor;
    int         err;
    int         n;
    bit         steep;
    line_mode_e mode;
    pixel_t     px;
    x      = sx;
    y      = sy;
    ddx    = int'(ex) - x;
    ddy    = int'(ey) - y;
    adx    = (ddx < 0) ? -ddx : ddx;
    ady    = (ddy < 0) ? -ddy : ddy;
    step_x = (ddx > 0) ? 1 : ((ddx < 0) ? -1 : 0);
    step_y = (ddy > 0) ? 1 : ((ddy < 0) ? -1 : 0);
    steep  = ady > adx;
    major  = steep ? ady : adx;
    minor  = steep ? adx : ady;
    if (major == 0) begin
      mode = LINE_IDLE;
    end else if (adx == 0 || ady == 0) begin
      mode = LINE_AXIS;
    end else if (adx == ady) begin
      mode = LINE_DIAG;
    end else begin
      mode = LINE_GENERAL;
    end
    err = 2 * minor - major;
    n   = major;
    while (n > 0) begin
      px.x    = coord_t'(x);
      px.y    = coord_t'(y);
      px.last = (n == 1);
      pending_pixels.push_back(px);
      if (mode != LINE_GENERAL) begin
        x += step_x;
        y += step_y;
      end else begin
        // take the minor step first when the error has gone positive
        if (err > 0) begin
          if (steep) x += step_x;
          else       y += step_y;
          err -= 2 * major;
        end
        if (steep) y += step_y;
        else       x += step_x;
        err += 2 * minor;
      end
      n--;
    end
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -32) return -32;
    if (v > 31) return 31;
    return v;
  endfunction

  function automatic seg_row_t random_row();
    seg_row_t r;
    int       kind;
    int       ad;
    int       lo;
    r        = '{default: 0};
    r.sx     = int'($urandom_range(0, 63)) - 32;
    r.sy     = int'($urandom_range(0, 63)) - 32;
    r.ex     = int'($urandom_range(0, 63)) - 32;
    r.ey     = int'($urandom_range(0, 63)) - 32;
    kind     = $urandom_range(0, 99);
    if (kind < 15) begin
      // axis-aligned
      if ($urandom_range(0, 1)) r.ey = r.sy;
      else                      r.ex = r.sx;
    end else if (kind < 27) begin
      // 45 degrees: place y so both ends fit
      ad = (r.ex > r.sx) ? r.ex - r.sx : r.sx - r.ex;
      lo = int'($urandom_range(0, 63 - ad)) - 32;
      if ($urandom_range(0, 1)) begin
        r.sy = lo;
        r.ey = lo + ad;
      end else begin
        r.sy = lo + ad;
        r.ey = lo;
      end
    end else if (kind < 37) begin
      // short segment around the start point
      r.ex = clamp_coord(r.sx + int'($urandom_range(0, 6)) - 3);
      r.ey = clamp_coord(r.sy + int'($urandom_range(0, 6)) - 3);
    end else if (kind < 42) begin
      r.ex = r.sx;
      r.ey = r.sy;
    end
    return r;
  endfunction

  task automatic send_seg(seg_row_t r);
    pixel_t px;
    while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      seg_if.valid = 1'b0;
      @(negedge clk_i);
    end
    seg_if.start_x = coord_t'(r.sx);
    seg_if.start_y = coord_t'(r.sy);
    seg_if.end_x   = coord_t'(r.ex);
    seg_if.end_y   = coord_t'(r.ey);
    seg_if.valid   = 1'b1;
    do @(posedge clk_i); while (!seg_if.ready);
    if (r.golden) begin
      if (r.g_pix) begin
        px.x    = coord_t'(r.gx);
        px.y    = coord_t'(r.gy);
        px.last = 1'b1;
        pending_pixels.push_back(px);
      end
    end else begin
      predict_line(coord_t'(r.sx), coord_t'(r.sy), coord_t'(r.ex), coord_t'(r.ey));
    end
    @(negedge clk_i);
  endtask

  task automatic drain_pixels();
    seg_if.valid = 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) pix_if.ready = !(stall_on && $urandom_range(0, 99) < IDLE_PERCENT);
  end

  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel (%0d, %0d) last=%0b",
               pix_if.pixel_x, pix_if.pixel_y, pix_if.is_last);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        if (pix_if.pixel_x !== want.x) begin
          $error("pixel_x: expected %0d, got %0d", want.x, pix_if.pixel_x);
          mismatches++;
        end
        if (pix_if.pixel_y !== want.y) begin
          $error("pixel_y: expected %0d, got %0d", want.y, pix_if.pixel_y);
          mismatches++;
        end
        if (pix_if.is_last !== want.last) begin
          $error("is_last: expected %0b, got %0b", want.last, pix_if.is_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    mismatches     = 0;
    cycles         = 0;
    gaps_on        = 1'b1;
    stall_on       = 1'b1;
    rst_ni         = 1'b0;
    seg_if.valid   = 1'b0;
    seg_if.start_x = '0;
    seg_if.start_y = '0;
    seg_if.end_x   = '0;
    seg_if.end_y   = '0;
    pix_if.ready   = 1'b0;
    // hold reset over several rising edges, release on a falling edge
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) send_seg(directed_rows[i]);
    drain_pixels();

    // calm stretch first: back-to-back requests, receiver always ready
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i == CALM_ITEMS) begin
        gaps_on  = 1'b1;
        stall_on = 1'b1;
      end
      if (i == N_RANDOM / 2) drain_pixels();
      send_seg(random_row());
    end

    drain_pixels();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/bls_pkg.sv
hw/rtl/bls_seg_if.sv
hw/rtl/bls_pix_if.sv
hw/rtl/bls_front.sv
hw/rtl/bls_queue.sv
hw/rtl/bls_back.sv
hw/rtl/bresenham_line_stepper.sv
tb/sv/tb_top.sv
